[rtl/scd_pkg.sv]
// Shared types and constants for the serial command decoder.
// Holds reply codes, beat widths and the 7-segment pattern lookup.
// No dependencies; imported by the decoder, its port checker and the bench.
package scd_pkg;

  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned DriveW   = 14;
  localparam int unsigned DutyW    = 8;

  typedef enum logic [1:0] {
    ReplyNone = 2'd0,
    ReplyAck  = 2'd1,
    ReplyErr  = 2'd2
  } reply_e;

  // Bit positions of the fields inside the result beat.
  localparam int unsigned OutReplyLo   = 0;
  localparam int unsigned OutLedBit    = 2;
  localparam int unsigned OutViewLo    = 3;
  localparam int unsigned OutWriteBit  = 5;
  localparam int unsigned OutClearBit  = 6;
  localparam int unsigned OutDriveLo   = 7;
  localparam int unsigned OutUpdateBit = 21;
  localparam int unsigned OutDutyLo    = 22;

  function automatic logic [6:0] seg_pattern(input logic [3:0] digit);
    logic [6:0] pat;
    case (digit)
      4'd0:    pat = 7'h3F;
      4'd1:    pat = 7'h06;
      4'd2:    pat = 7'h5B;
      4'd3:    pat = 7'h4F;
      4'd4:    pat = 7'h66;
      4'd5:    pat = 7'h6D;
      4'd6:    pat = 7'h7D;
      4'd7:    pat = 7'h27;
      4'd8:    pat = 7'h7F;
      4'd9:    pat = 7'h6F;
      default: pat = 7'h00;
    endcase
    return pat;
  endfunction

endpackage

[rtl/serial_command_decoder.sv]
// Serial command decoder: parses ASCII command bytes into LED, LCD, digit and fan controls.
// Depends on scd_pkg for reply codes, beat layout and segment patterns.
//
// One received byte enters per slave beat on s_axis_tdata. Every byte produces
// exactly one result beat on the master side, carrying the reply code, the LED
// and LCD view levels after the byte, the digit display strobes and drive word,
// and the fan duty strobe and compare value. The parser state and the result
// register are updated in the same edge that accepts the byte, so a result
// appears in the cycle after its byte is accepted.
// Throughput is one byte per cycle; the single output register is refilled in
// the cycle it is drained, so s_axis_tready stays high while m_axis_tready is.
// When the receiver stalls, the pending result holds and s_axis_tready drops
// until that result is taken. The longest path is the duty scaling, a single
// 8 by 18 bit constant multiply followed by a saturation compare.
// Reset clears the parser to idle, turns the LED off, selects the names banner
// view, sets the duty to zero and empties the output register.
module serial_command_decoder (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // received_byte[7:0]
  input  logic [scd_pkg::InDataW-1:0]   s_axis_tdata,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // reply[1:0], led_on[2], lcd_view[4:3], display_write[5], display_clear[6],
  // display_drive[20:7], duty_update[21], duty_compare[29:22], zero[31:30]
  output logic [scd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import scd_pkg::*;

  localparam logic [4:0] PosIdle  = 5'd0;
  localparam logic [4:0] PosL     = 5'd1;
  localparam logic [4:0] PosLs    = 5'd2;
  localparam logic [4:0] PosLc    = 5'd3;
  localparam logic [4:0] PosS     = 5'd6;
  localparam logic [4:0] PosD     = 5'd8;
  localparam logic [4:0] PosDn    = 5'd9;
  localparam logic [4:0] PosLcd   = 5'd10;
  localparam logic [4:0] PosLcdo  = 5'd11;
  localparam logic [4:0] PosLcdof = 5'd12;
  localparam logic [4:0] PosC     = 5'd13;
  localparam logic [4:0] PosSs    = 5'd14;
  localparam logic [4:0] PosSsx   = 5'd15;
  localparam logic [4:0] PosSsxy  = 5'd16;

  localparam logic [7:0] ChC  = 8'h43;
  localparam logic [7:0] ChD  = 8'h44;
  localparam logic [7:0] ChF  = 8'h46;
  localparam logic [7:0] ChL  = 8'h4C;
  localparam logic [7:0] ChN  = 8'h4E;
  localparam logic [7:0] ChO  = 8'h4F;
  localparam logic [7:0] ChS  = 8'h53;
  localparam logic [7:0] Ch0  = 8'h30;
  localparam logic [7:0] Ch1  = 8'h31;
  localparam logic [7:0] Ch3  = 8'h33;
  localparam logic [7:0] Ch4  = 8'h34;
  localparam logic [7:0] Ch9  = 8'h39;

  localparam logic [1:0] ViewOff    = 2'd0;
  localparam logic [1:0] ViewBanner = 2'd1;
  localparam logic [1:0] ViewSpeed  = 2'd2;

  // 255/100 in 2.16 fixed point, rounded up; exact floor for percents up to 199.
  localparam logic [17:0] DutyScale = 18'd167117;

  logic [4:0]        pos_q, pos_d;
  logic [1:0]        digit_q, digit_d;
  logic              hund_q, hund_d;
  logic [3:0]        tens_q, tens_d;
  logic              led_q, led_d;
  logic [1:0]        view_q, view_d;
  logic [DutyW-1:0]  duty_q, duty_d;

  logic              out_valid_q;
  logic [OutDataW-1:0] out_data_q, out_data_d;

  logic [7:0]        ch;
  logic              in_fire;
  logic              is_dec;
  logic              bad;
  reply_e            reply;
  logic              dwrite, dclear, dupdate;
  logic [DriveW-1:0] ddrive;
  logic [7:0]        pct;
  logic [25:0]       scaled;
  logic [9:0]        duty_raw;

  assign ch      = s_axis_tdata;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign is_dec  = ch inside {[Ch0:Ch9]};

  assign pct      = ({7'd0, hund_q} * 8'd100) + ({4'd0, tens_q} * 8'd10) + {4'd0, ch[3:0]};
  assign scaled   = {18'd0, pct} * {8'd0, DutyScale};
  assign duty_raw = scaled[25:16];

  always_comb begin
    pos_d   = PosIdle;
    digit_d = digit_q;
    hund_d  = hund_q;
    tens_d  = tens_q;
    led_d   = led_q;
    view_d  = view_q;
    duty_d  = duty_q;
    bad     = 1'b0;
    reply   = ReplyNone;
    dwrite  = 1'b0;
    dclear  = 1'b0;
    dupdate = 1'b0;
    ddrive  = '0;
    case (pos_q)
      PosIdle: begin
        if (ch == ChL) pos_d = PosL;
        else if (ch == ChS) pos_d = PosS;
        else if (ch == ChD) pos_d = PosD;
        else if (ch == ChC) pos_d = PosC;
        else bad = 1'b1;
      end
      PosL: begin
        if (ch == ChS) pos_d = PosLs;
        else if (ch == ChC) pos_d = PosLc;
        else bad = 1'b1;
      end
      PosLs: begin
        if (ch == Ch4) begin
          led_d = 1'b1;
          reply = ReplyAck;
        end else bad = 1'b1;
      end
      PosLc: begin
        if (ch == Ch4) begin
          led_d = 1'b0;
          reply = ReplyAck;
        end else if (ch == ChD) pos_d = PosLcd;
        else bad = 1'b1;
      end
      PosS: begin
        if (ch == Ch3) reply = ReplyAck;
        else if (ch == ChS) pos_d = PosSs;
        else bad = 1'b1;
      end
      PosD: begin
        if (ch inside {[Ch1:Ch4]}) begin
          digit_d = ch[1:0] - 2'd1;
          pos_d   = PosDn;
        end else bad = 1'b1;
      end
      PosDn: begin
        if (ch == ChC) begin
          dclear = 1'b1;
          reply  = ReplyAck;
        end else if (is_dec) begin
          ddrive = {4'b1000 >> digit_q, 3'b000, seg_pattern(ch[3:0])};
          dwrite = 1'b1;
          reply  = ReplyAck;
        end else bad = 1'b1;
      end
      PosLcd: begin
        if (ch == ChO) pos_d = PosLcdo;
        else bad = 1'b1;
      end
      PosLcdo: begin
        if (ch == ChN) begin
          view_d = ViewBanner;
          reply  = ReplyAck;
        end else if (ch == ChF) pos_d = PosLcdof;
        else bad = 1'b1;
      end
      PosLcdof: begin
        if (ch == ChF) begin
          view_d = ViewOff;
          reply  = ReplyAck;
        end else bad = 1'b1;
      end
      PosC: begin
        if (ch == ChS) begin
          view_d = ViewSpeed;
          reply  = ReplyAck;
        end else bad = 1'b1;
      end
      PosSs: begin
        if (ch inside {Ch0, Ch1}) begin
          hund_d = ch[0];
          pos_d  = PosSsx;
        end else bad = 1'b1;
      end
      PosSsx: begin
        if (is_dec) begin
          tens_d = ch[3:0];
          pos_d  = PosSsxy;
        end else bad = 1'b1;
      end
      PosSsxy: begin
        if (is_dec) begin
          duty_d  = (duty_raw > 10'd255) ? 8'hFF : duty_raw[7:0];
          dupdate = 1'b1;
          view_d  = ViewOff;
          reply   = ReplyAck;
        end else bad = 1'b1;
      end
      default: begin
        bad = 1'b1;
      end
    endcase
    if (bad) begin
      reply = ReplyErr;
      pos_d = PosIdle;
    end
    out_data_d = {2'b00, duty_d, dupdate, ddrive, dclear, dwrite, view_d, led_d, reply};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosIdle;
      digit_q     <= 2'd0;
      hund_q      <= 1'b0;
      tens_q      <= 4'd0;
      led_q       <= 1'b0;
      view_q      <= ViewBanner;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        pos_q   <= pos_d;
        digit_q <= digit_d;
        hund_q  <= hund_d;
        tens_q  <= tens_d;
        led_q   <= led_d;
        view_q  <= view_d;
        duty_q  <= duty_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

[rtl/scd_port_checker.sv]
// Port-level checker for the serial command decoder, bound to its top level.
// Depends on scd_pkg for the result beat layout and reply codes.
module scd_port_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [scd_pkg::OutDataW-1:0]  m_axis_tdata
);
  import scd_pkg::*;

  logic dwrite, dclear;
  logic [1:0] reply;
  logic [DriveW-1:0] drive;

  assign dwrite = m_axis_tdata[OutWriteBit];
  assign dclear = m_axis_tdata[OutClearBit];
  assign reply  = m_axis_tdata[OutReplyLo +: 2];
  assign drive  = m_axis_tdata[OutDriveLo +: DriveW];

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("Stalled result beat changed.");

  a_reply_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (reply == ReplyNone) || (reply == ReplyAck) || (reply == ReplyErr))
    else $error("Reply code out of range.");

  a_strobe_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(dwrite && dclear) && !((dwrite || dclear) && reply != ReplyAck))
    else $error("Display strobes inconsistent with reply.");

  a_drive_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !dwrite |-> drive == '0)
    else $error("Display drive nonzero without a write strobe.");

  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid || m_axis_tready |-> s_axis_tready)
    else $error("Input stalled although the result register can take a beat.");

endmodule

bind serial_command_decoder scd_port_checker u_scd_port_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[bench/serial_command_decoder_tb.sv]
// Self-checking bench for serial_command_decoder: streams ASCII command bytes and
// compares every result beat against a built-in model of the command parser.
// Depends on scd_pkg for the reply codes and the bit layout of the result beat.
module serial_command_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import scd_pkg::*;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned PhaseLen   = 350;
  localparam int unsigned RandItems  = 1000;
  localparam string       NearMiss   = "05/:2Ec ";
  localparam logic [6:0]  SegOf [0:9] = '{7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66,
                                          7'h6D, 7'h7D, 7'h27, 7'h7F, 7'h6F};

  typedef enum logic [4:0] {
    PosIdle, PosL, PosLs, PosLc, PosS, PosD, PosDn, PosLcd, PosLcdo, PosLcdof,
    PosC, PosSs, PosSsx, PosSsxy
  } parse_pos_e;

  typedef struct packed {
    reply_e      reply;
    logic        led_on;
    logic [1:0]  lcd_view;
    logic        display_write;
    logic        display_clear;
    logic [13:0] display_drive;
    logic        duty_update;
    logic [7:0]  duty_compare;
  } status_t;

  typedef struct {
    logic [7:0] data;
    bit         hold;
  } rx_byte_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;

  rx_byte_t   rx_bytes [$];
  status_t    status_due [$];
  bit         hold_next = 1'b0;
  int         n_acc = 0;
  int         n_res = 0;
  int         n_fail = 0;
  int         n_cycles = 0;

  parse_pos_e pos = PosIdle;
  logic [1:0] digit_sel = '0;
  logic       hund = 1'b0;
  logic [3:0] tens = '0;
  logic       led = 1'b0;
  logic [1:0] view = 2'd1;
  logic [7:0] duty = '0;

  serial_command_decoder u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int idle_pct(input bit sender);
    if (n_acc < PhaseLen) return sender ? 9 : 88;
    if (n_acc < 2 * PhaseLen) return sender ? 88 : 9;
    return 0;
  endfunction

  task automatic decode_byte(input logic [7:0] c, output status_t r);
    parse_pos_e nxt;
    logic       bad;
    int         pct;
    int         scaled;
    r = '0;
    r.reply = ReplyNone;
    nxt = PosIdle;
    bad = 1'b0;
    case (pos)
      PosIdle: begin
        if (c == "L") nxt = PosL;
        else if (c == "S") nxt = PosS;
        else if (c == "D") nxt = PosD;
        else if (c == "C") nxt = PosC;
        else bad = 1'b1;
      end
      PosL: begin
        if (c == "S") nxt = PosLs;
        else if (c == "C") nxt = PosLc;
        else bad = 1'b1;
      end
      PosLs: begin
        if (c == "4") begin
          led = 1'b1;
          r.reply = ReplyAck;
        end else bad = 1'b1;
      end
      PosLc: begin
        if (c == "4") begin
          led = 1'b0;
          r.reply = ReplyAck;
        end else if (c == "D") nxt = PosLcd;
        else bad = 1'b1;
      end
      PosS: begin
        if (c == "3") r.reply = ReplyAck;
        else if (c == "S") nxt = PosSs;
        else bad = 1'b1;
      end
      PosD: begin
        if (c >= "1" && c <= "4") begin
          digit_sel = 2'(c - "1");
          nxt = PosDn;
        end else bad = 1'b1;
      end
      PosDn: begin
        if (c == "C") begin
          r.display_clear = 1'b1;
          r.reply = ReplyAck;
        end else if (c >= "0" && c <= "9") begin
          r.display_drive = (14'h2000 >> digit_sel) | 14'(SegOf[c[3:0]]);
          r.display_write = 1'b1;
          r.reply = ReplyAck;
        end else bad = 1'b1;
      end
      PosLcd: begin
        if (c == "O") nxt = PosLcdo;
        else bad = 1'b1;
      end
      PosLcdo: begin
        if (c == "N") begin
          view = 2'd1;
          r.reply = ReplyAck;
        end else if (c == "F") nxt = PosLcdof;
        else bad = 1'b1;
      end
      PosLcdof: begin
        if (c == "F") begin
          view = 2'd0;
          r.reply = ReplyAck;
        end else bad = 1'b1;
      end
      PosC: begin
        if (c == "S") begin
          view = 2'd2;
          r.reply = ReplyAck;
        end else bad = 1'b1;
      end
      PosSs: begin
        if (c == "0" || c == "1") begin
          hund = c[0];
          nxt = PosSsx;
        end else bad = 1'b1;
      end
      PosSsx: begin
        if (c >= "0" && c <= "9") begin
          tens = c[3:0];
          nxt = PosSsxy;
        end else bad = 1'b1;
      end
      PosSsxy: begin
        if (c >= "0" && c <= "9") begin
          pct = hund * 100 + tens * 10 + c[3:0];
          scaled = pct * 255 / 100;
          duty = (scaled > 255) ? 8'd255 : 8'(scaled);
          r.duty_update = 1'b1;
          view = 2'd0;
          r.reply = ReplyAck;
        end else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      r.reply = ReplyErr;
      nxt = PosIdle;
    end
    pos = nxt;
    r.led_on = led;
    r.lcd_view = view;
    r.duty_compare = duty;
  endtask

  task automatic push_byte(input logic [7:0] b);
    rx_bytes.push_back('{data: b, hold: hold_next});
    hold_next = 1'b0;
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i]);
  endtask

  function automatic string random_command();
    string cmd;
    case ($urandom_range(0, 8))
      0: cmd = "LS4";
      1: cmd = "LC4";
      2: cmd = "LCDON";
      3: cmd = "LCDOFF";
      4: cmd = "CS";
      5: cmd = "SS3";
      6: cmd = $sformatf("SS%0d%0d%0d", $urandom_range(0, 1), $urandom_range(0, 9),
                         $urandom_range(0, 9));
      7: cmd = $sformatf("D%0dC", $urandom_range(1, 4));
      default: cmd = $sformatf("D%0d%0d", $urandom_range(1, 4), $urandom_range(0, 9));
    endcase
    return cmd;
  endfunction

  task automatic push_noise();
    string cmd;
    int    keep;
    cmd = random_command();
    keep = $urandom_range(0, cmd.len() - 1);
    for (int i = 0; i < keep; i++) push_byte(cmd[i]);
    if ($urandom_range(0, 1)) push_byte(8'($urandom_range(0, 255)));
    else push_byte(NearMiss[$urandom_range(0, NearMiss.len() - 1)]);
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      n_fail++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : p_drive
    status_t res;
    bit      accepted;
    bit      go;
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
      s_tdata <= '0;
    end else begin
      accepted = s_tvalid && s_tready;
      if (accepted) begin
        decode_byte(rx_bytes[0].data, res);
        status_due.push_back(res);
        void'(rx_bytes.pop_front());
        n_acc <= n_acc + 1;
      end
      if (!s_tvalid || accepted) begin
        go = rx_bytes.size() > 0 && $urandom_range(0, 99) >= idle_pct(1'b1);
        if (go && rx_bytes[0].hold && (accepted || n_acc != n_res)) go = 1'b0;
        s_tvalid <= go;
        if (go) s_tdata <= rx_bytes[0].data;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : p_monitor
    status_t want;
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        n_res <= n_res + 1;
        if (status_due.size() == 0) begin
          $error("result beat 0x%08h arrived with no byte pending", m_tdata);
          n_fail++;
        end else begin
          want = status_due.pop_front();
          check_field("reply", want.reply, m_tdata[OutReplyLo +: 2]);
          check_field("led_on", want.led_on, m_tdata[OutLedBit]);
          check_field("lcd_view", want.lcd_view, m_tdata[OutViewLo +: 2]);
          check_field("display_write", want.display_write, m_tdata[OutWriteBit]);
          check_field("display_clear", want.display_clear, m_tdata[OutClearBit]);
          check_field("display_drive", want.display_drive, m_tdata[OutDriveLo +: DriveW]);
          check_field("duty_update", want.duty_update, m_tdata[OutUpdateBit]);
          check_field("duty_compare", want.duty_compare, m_tdata[OutDutyLo +: DutyW]);
        end
      end
      m_tready <= ($urandom_range(0, 99) >= idle_pct(1'b0));
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles > CycleLimit) begin
      $display("[serial_command_decoder] ERROR");
      $finish;
    end
  end

  initial begin
    push_text("LS4");
    push_text("LC4");
    push_text("LCDOFF");
    push_text("CS");
    push_text("SS3");
    push_text("SS199");
    push_text("D49");
    push_byte(8'hFF);
    hold_next = 1'b1;
    while (rx_bytes.size() < 26 + RandItems) begin
      if (rx_bytes.size() >= 700 && rx_bytes.size() < 704) hold_next = 1'b1;
      case ($urandom_range(0, 9))
        0: push_byte(8'($urandom_range(0, 255)));
        1: push_noise();
        default: push_text(random_command());
      endcase
    end

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (rx_bytes.size() != 0 || n_acc != n_res) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (status_due.size() != 0) begin
      $error("%0d results never arrived", status_due.size());
    end
    if (n_fail == 0 && status_due.size() == 0) begin
      $display("[serial_command_decoder] OK");
    end else begin
      $display("[serial_command_decoder] ERROR");
    end
    $finish;
  end

endmodule
